// File: hdl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

	localparam int PRIO_W    = 16;
	localparam int PAY_W     = 32;
	localparam int CNT_OUT_W = 5;
	localparam int STS_W     = 2;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [STS_W-1:0] STS_DONE      = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL_DROP = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic             load;
		logic             insert;
		logic             remove;
		logic [STS_W-1:0] code;
	} sspq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
	} sspq_sts_t;

endpackage

// File: hdl/sspq_item_if.sv
// ----------------------------------------------------------------------------
// sspq_item_if
// Request channel of the priority queue: insert or remove.
// ----------------------------------------------------------------------------
interface sspq_item_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [sspq_pkg::PRIO_W-1:0]  in_priority;
	logic [sspq_pkg::PAY_W-1:0]   in_payload;

	modport source (output valid, action, in_priority, in_payload, input ready);
	modport sink   (input valid, action, in_priority, in_payload, output ready);
endinterface

// File: hdl/sspq_result_if.sv
// ----------------------------------------------------------------------------
// sspq_result_if
// Result channel of the priority queue: one result per request.
// ----------------------------------------------------------------------------
interface sspq_result_if;
	logic                            valid;
	logic                            ready;
	logic [sspq_pkg::STS_W-1:0]      status;
	logic                            out_valid;
	logic [sspq_pkg::PRIO_W-1:0]     out_priority;
	logic [sspq_pkg::PAY_W-1:0]      out_payload;
	logic                            head_valid;
	logic [sspq_pkg::PRIO_W-1:0]     head_priority;
	logic [sspq_pkg::PAY_W-1:0]      head_payload;
	logic [sspq_pkg::CNT_OUT_W-1:0]  held_count;

	modport source (output valid, status, out_valid, out_priority, out_payload,
		head_valid, head_priority, head_payload, held_count, input ready);
	modport sink   (input valid, status, out_valid, out_priority, out_payload,
		head_valid, head_priority, head_payload, held_count, output ready);
endinterface

// File: hdl/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// sspq_ctrl
// Handshake controller: accepts a request whenever the result register is
// free or draining, and decides the queue operation from the datapath flags.
// ----------------------------------------------------------------------------
module sspq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_action,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  sspq_pkg::sspq_sts_t  sts,
	output sspq_pkg::sspq_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_nxt;
	logic accept;

	assign item_ready   = (state_q == ST_IDLE) || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = (state_q == ST_HOLD);

	always_comb begin
		cmd.load   = accept;
		cmd.insert = accept && (item_action == sspq_pkg::ACT_INSERT) && !sts.full;
		cmd.remove = accept && (item_action == sspq_pkg::ACT_REMOVE) && !sts.empty;
		if (item_action == sspq_pkg::ACT_INSERT) begin
			cmd.code = sts.full ? sspq_pkg::STS_FULL_DROP : sspq_pkg::STS_DONE;
		end else begin
			cmd.code = sts.empty ? sspq_pkg::STS_EMPTY : sspq_pkg::STS_DONE;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_HOLD;
			end
			ST_HOLD: begin
				if (!accept && result_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: hdl/sspq_datapath.sv
// ----------------------------------------------------------------------------
// sspq_datapath
// Sorted slot array with one comparator per slot. An insert shifts the tail
// up one slot from the insertion point; a remove shifts everything down.
// ----------------------------------------------------------------------------
module sspq_datapath #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sspq_pkg::sspq_cmd_t               cmd,
	input  logic [sspq_pkg::PRIO_W-1:0]       in_priority,
	input  logic [sspq_pkg::PAY_W-1:0]        in_payload,
	output sspq_pkg::sspq_sts_t               sts,
	output logic [sspq_pkg::STS_W-1:0]        status,
	output logic                              out_valid,
	output logic [sspq_pkg::PRIO_W-1:0]       out_priority,
	output logic [sspq_pkg::PAY_W-1:0]        out_payload,
	output logic                              head_valid,
	output logic [sspq_pkg::PRIO_W-1:0]       head_priority,
	output logic [sspq_pkg::PAY_W-1:0]        head_payload,
	output logic [sspq_pkg::CNT_OUT_W-1:0]    held_count
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [sspq_pkg::PRIO_W-1:0] prio_q [DEPTH];
	logic [PAYLOAD_BITS-1:0]     pay_q  [DEPTH];
	logic [CW-1:0]               count_q;

	logic [sspq_pkg::PRIO_W-1:0] prio_nxt [DEPTH];
	logic [PAYLOAD_BITS-1:0]     pay_nxt  [DEPTH];
	logic [CW-1:0]               count_nxt;
	logic [DEPTH-1:0]            take;
	logic [DEPTH:0]              take_ext;
	logic [63:0]                 pay_in_ext;
	logic [PAYLOAD_BITS-1:0]     pay_in;
	logic                        op;

	logic [sspq_pkg::PRIO_W-1:0] head_prio_nxt;
	logic [PAYLOAD_BITS-1:0]     head_pay_nxt;
	logic [63:0]                 out_pay_ext;
	logic [63:0]                 head_pay_ext;
	logic [8:0]                  count_ext;

	assign pay_in_ext = 64'(in_payload);
	assign pay_in     = pay_in_ext[PAYLOAD_BITS-1:0];
	assign op         = cmd.insert || cmd.remove;

	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(DEPTH));

	// take[i]: slot i lies at or beyond the insertion point (monotone, list is sorted)
	assign take_ext[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		assign take[i]       = (count_q <= CW'(i)) || (prio_q[i] > in_priority);
		assign take_ext[i+1] = take[i];

		logic [sspq_pkg::PRIO_W-1:0] up_prio;
		logic [PAYLOAD_BITS-1:0]     up_pay;
		logic [sspq_pkg::PRIO_W-1:0] dn_prio;
		logic [PAYLOAD_BITS-1:0]     dn_pay;

		if (i == 0) begin : g_first
			assign up_prio = in_priority;
			assign up_pay  = pay_in;
		end else begin : g_mid
			assign up_prio = prio_q[i-1];
			assign up_pay  = pay_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign dn_prio = prio_q[i];
			assign dn_pay  = pay_q[i];
		end else begin : g_body
			assign dn_prio = prio_q[i+1];
			assign dn_pay  = pay_q[i+1];
		end

		always_comb begin
			prio_nxt[i] = prio_q[i];
			pay_nxt[i]  = pay_q[i];
			if (cmd.insert) begin
				if (take[i] && !take_ext[i]) begin
					prio_nxt[i] = in_priority;
					pay_nxt[i]  = pay_in;
				end else if (take[i]) begin
					prio_nxt[i] = up_prio;
					pay_nxt[i]  = up_pay;
				end
			end else if (cmd.remove) begin
				prio_nxt[i] = dn_prio;
				pay_nxt[i]  = dn_pay;
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.insert) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.remove) begin
			count_nxt = count_q - CW'(1);
		end
	end

	assign head_prio_nxt = prio_nxt[0];
	assign head_pay_nxt  = pay_nxt[0];
	assign out_pay_ext   = 64'(pay_q[0]);
	assign head_pay_ext  = 64'(head_pay_nxt);
	assign count_ext     = 9'(count_nxt);

	always_ff @(posedge clk) begin
		if (op) begin
			for (int k = 0; k < DEPTH; k++) begin
				prio_q[k] <= prio_nxt[k];
				pay_q[k]  <= pay_nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status        <= cmd.code;
			out_valid     <= cmd.remove;
			out_priority  <= cmd.remove ? prio_q[0] : '0;
			out_payload   <= cmd.remove ? out_pay_ext[sspq_pkg::PAY_W-1:0] : '0;
			head_valid    <= (count_nxt != '0);
			head_priority <= (count_nxt != '0) ? head_prio_nxt : '0;
			head_payload  <= (count_nxt != '0) ? head_pay_ext[sspq_pkg::PAY_W-1:0] : '0;
			held_count    <= count_ext[sspq_pkg::CNT_OUT_W-1:0];
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not add one entry");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |=> count_q == $past(count_q) - CW'(1))
		else $error("remove did not take one entry");

	a_no_op_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.insert || cmd.remove) |=> $stable(count_q))
		else $error("count changed without an operation");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> prio_q[0] <= prio_q[1])
		else $error("head slot out of order");

endmodule

// File: hdl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue, ascending order, FIFO among equal priorities.
// ----------------------------------------------------------------------------
// Takes one request per clock unless the receiver holds back the result,
// and returns its result in the next cycle from a result register; a new
// request is taken in the same cycle the previous result is taken. Each
// slot has its own comparator against the incoming priority, so an insert
// finds its place and shifts the tail, and a remove shifts every slot down,
// as the request is accepted. An insert on a full queue is dropped (status
// 2), a remove on an empty queue returns status 1. Every result carries the
// head and the count after the request.
module stable_sorted_priority_queue #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	sspq_item_if.sink     item,
	sspq_result_if.source result
);

	sspq_pkg::sspq_cmd_t cmd;
	sspq_pkg::sspq_sts_t sts;

	sspq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_action  (item.action),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	sspq_datapath #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_priority   (item.in_priority),
		.in_payload    (item.in_payload),
		.sts           (sts),
		.status        (result.status),
		.out_valid     (result.out_valid),
		.out_priority  (result.out_priority),
		.out_payload   (result.out_payload),
		.head_valid    (result.head_valid),
		.head_priority (result.head_priority),
		.head_payload  (result.head_payload),
		.held_count    (result.held_count)
	);

endmodule

// File: sim/tb_stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue
// Self-checking bench: directed requests, then random insert/remove traffic
// against a behavioral sorted-queue predictor, with random idling on both
// channels, long receiver hold-offs and drain pauses.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;

	localparam int DEPTH       = 16;
	localparam int N_RANDOM    = 1030;
	localparam int RX_HOLD     = 80;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [sspq_pkg::STS_W-1:0]     status;
		logic                           out_valid;
		logic [sspq_pkg::PRIO_W-1:0]    out_priority;
		logic [sspq_pkg::PAY_W-1:0]     out_payload;
		logic                           head_valid;
		logic [sspq_pkg::PRIO_W-1:0]    head_priority;
		logic [sspq_pkg::PAY_W-1:0]     head_payload;
		logic [sspq_pkg::CNT_OUT_W-1:0] held_count;
	} result_t;

	typedef struct packed {
		logic                        act;
		logic [sspq_pkg::PRIO_W-1:0] prio;
		logic [sspq_pkg::PAY_W-1:0]  pay;
		logic                        typed;
		result_t                     res;
	} dir_row_t;

	localparam result_t NO_EXP = '0;

	// typed rows: results readable straight off the queue contents
	localparam dir_row_t DIRECTED [0:22] = '{
		'{sspq_pkg::ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1,
			'{sspq_pkg::STS_EMPTY, 1'b0, 16'h0, 32'h0,
				1'b0, 16'h0000, 32'h0000_0000, 5'd0}},
		'{sspq_pkg::ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{sspq_pkg::STS_DONE, 1'b0, 16'h0, 32'h0,
				1'b1, 16'hFFFF, 32'hFFFF_FFFF, 5'd1}},
		'{sspq_pkg::ACT_INSERT, 16'h0000, 32'h0000_0000, 1'b1,
			'{sspq_pkg::STS_DONE, 1'b0, 16'h0, 32'h0,
				1'b1, 16'h0000, 32'h0000_0000, 5'd2}},
		'{sspq_pkg::ACT_INSERT, 16'h1234, 32'h0000_000A, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h1234, 32'h0000_000B, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h0000, 32'h0000_0001, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1,
			'{sspq_pkg::STS_DONE, 1'b1, 16'h0, 32'h0,
				1'b1, 16'h0000, 32'h0000_0001, 5'd4}},
		'{sspq_pkg::ACT_INSERT, 16'h8000, 32'h0000_00C1, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h7FFF, 32'h0000_00C2, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h1234, 32'h0000_00C3, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'hFFFF, 32'h0000_00C4, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h0001, 32'h0000_00C5, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h00FF, 32'h0000_00C6, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'hFF00, 32'h0000_00C7, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h5555, 32'h5555_5555, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h8000, 32'h0000_00CA, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'h0000, 32'h0000_00CB, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_INSERT, 16'hFFFE, 32'h0000_00CC, 1'b0, NO_EXP},
		// full: dropped, queue untouched
		'{sspq_pkg::ACT_INSERT, 16'h0000, 32'hDEAD_BEEF, 1'b1,
			'{sspq_pkg::STS_FULL_DROP, 1'b0, 16'h0, 32'h0,
				1'b1, 16'h0000, 32'h0000_0001, 5'd16}},
		'{sspq_pkg::ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1,
			'{sspq_pkg::STS_DONE, 1'b1, 16'h0, 32'h1,
				1'b1, 16'h0000, 32'h0000_00CB, 5'd15}},
		'{sspq_pkg::ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b0, NO_EXP},
		'{sspq_pkg::ACT_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_EXP}
	};

	logic clk;
	logic arst_n;

	sspq_item_if   req_ch ();
	sspq_result_if res_ch ();

	stable_sorted_priority_queue #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (sspq_pkg::PAY_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch),
		.result (res_ch)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// shadow of the sorted store
	logic [sspq_pkg::PRIO_W-1:0] q_prio [DEPTH];
	logic [sspq_pkg::PAY_W-1:0]  q_pay  [DEPTH];
	int                          q_count = 0;

	result_t pending_results [$];

	int  mismatches = 0;
	int  results_seen = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	bit  tx_steady = 1'b0;
	bit  rx_hold_req = 1'b0;
	int  n_insert = 0, n_drop = 0, n_remove = 0, n_empty = 0, peak = 0;

	function automatic result_t queue_step(logic act, logic [sspq_pkg::PRIO_W-1:0] prio,
			logic [sspq_pkg::PAY_W-1:0] pay);
		result_t r;
		int      pos;
		r = '0;
		r.status = sspq_pkg::STS_DONE;
		if (act == sspq_pkg::ACT_INSERT) begin
			if (q_count >= DEPTH) begin
				r.status = sspq_pkg::STS_FULL_DROP;
			end else begin
				// stable: goes after all entries of lower or equal priority
				pos = 0;
				while (pos < q_count && q_prio[pos] <= prio)
					pos++;
				for (int i = q_count; i > pos; i--) begin
					q_prio[i] = q_prio[i-1];
					q_pay[i]  = q_pay[i-1];
				end
				q_prio[pos] = prio;
				q_pay[pos]  = pay;
				q_count++;
			end
		end else begin
			if (q_count == 0) begin
				r.status = sspq_pkg::STS_EMPTY;
			end else begin
				r.out_valid    = 1'b1;
				r.out_priority = q_prio[0];
				r.out_payload  = q_pay[0];
				for (int i = 1; i < q_count; i++) begin
					q_prio[i-1] = q_prio[i];
					q_pay[i-1]  = q_pay[i];
				end
				q_count--;
			end
		end
		if (q_count > 0) begin
			r.head_valid    = 1'b1;
			r.head_priority = q_prio[0];
			r.head_payload  = q_pay[0];
		end
		r.held_count = q_count[sspq_pkg::CNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic offer_request(input logic act, input logic [sspq_pkg::PRIO_W-1:0] prio,
			input logic [sspq_pkg::PAY_W-1:0] pay, input logic typed,
			input result_t typed_res);
		int      gap;
		result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (tx_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.in_priority <= prio;
		req_ch.in_payload  <= pay;
		do @(posedge clk); while (!req_ch.ready);
		r = queue_step(act, prio, pay);
		if (act == sspq_pkg::ACT_INSERT) begin
			n_insert++;
			if (r.status == sspq_pkg::STS_FULL_DROP)
				n_drop++;
		end else begin
			n_remove++;
			if (r.status == sspq_pkg::STS_EMPTY)
				n_empty++;
		end
		if (q_count > peak)
			peak = q_count;
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic pause_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on result %0d, %s: expected %0h, got %0h",
					results_seen, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.status, res_ch.out_valid, res_ch.out_priority, res_ch.out_payload,
				res_ch.head_valid, res_ch.head_priority, res_ch.head_payload,
				res_ch.held_count};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no request outstanding", results_seen);
			end else begin
				want = pending_results.pop_front();
				compare_field("status",        want.status,        got.status);
				compare_field("out_valid",     want.out_valid,     got.out_valid);
				compare_field("out_priority",  want.out_priority,  got.out_priority);
				compare_field("out_payload",   want.out_payload,   got.out_payload);
				compare_field("head_valid",    want.head_valid,    got.head_valid);
				compare_field("head_priority", want.head_priority, got.head_priority);
				compare_field("head_payload",  want.head_payload,  got.head_payload);
				compare_field("held_count",    want.held_count,    got.held_count);
			end
			results_seen++;
		end
	end

	// receiver: stall rate changes from span to span; long hold on request
	initial begin
		int stall_pct = 0;
		int span = 0;
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
			end else begin
				if (span == 0) begin
					span = $urandom_range(16, 96);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 25;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
				end
				span--;
				res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int                          mode;
		int                          ins_pct;
		logic                        act;
		logic [sspq_pkg::PRIO_W-1:0] prio;
		logic [sspq_pkg::PAY_W-1:0]  pay;

		mode = 0;
		req_ch.valid       <= 1'b0;
		req_ch.action      <= sspq_pkg::ACT_INSERT;
		req_ch.in_priority <= '0;
		req_ch.in_payload  <= '0;
		arst_n             <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++)
			offer_request(DIRECTED[i].act, DIRECTED[i].prio, DIRECTED[i].pay,
				DIRECTED[i].typed, DIRECTED[i].res);
		pause_until_drained();

		for (int n = 0; n < N_RANDOM; n++) begin
			// phases: fill-heavy, drain-heavy or balanced
			if (n % 40 == 0)
				mode = (n == 0) ? 0 : $urandom_range(0, 2);
			if (n == 250 || n == 760)
				rx_hold_req = 1'b1;
			if (n == 520)
				pause_until_drained();
			tx_steady = (n >= 380 && n < 480);
			case (mode)
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			act = ($urandom_range(0, 99) < ins_pct) ? sspq_pkg::ACT_INSERT
				: sspq_pkg::ACT_REMOVE;
			// small range often, to get plenty of equal priorities
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: prio = 16'($urandom_range(0, 7));
				5, 6: prio = 16'($urandom_range(0, 16'hFFFF));
				7: prio = 16'h0000;
				8: prio = 16'hFFFF;
				default: prio = 16'($urandom_range(16'h7FF0, 16'h800F));
			endcase
			case ($urandom_range(0, 15))
				0: pay = '0;
				1: pay = '1;
				default: pay = $urandom;
			endcase
			offer_request(act, prio, pay, 1'b0, NO_EXP);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatches++;
			$display("%0d results never arrived", pending_results.size());
		end

		$display("sent %0d inserts (%0d dropped on full) and %0d removes (%0d on empty)",
			n_insert, n_drop, n_remove, n_empty);
		$display("checked %0d results, peak occupancy %0d of %0d, %0d mismatches",
			results_seen, peak, DEPTH, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
